>>> sv/bps_pkg.sv
// ----------------------------------------------------------------------------
// bps_pkg
// Shared constants and types of the buzzer pattern sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QUEUE_LIMIT = 10;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int TIME_W      = 16;
  localparam int ENTRY_W     = 2 * TIME_W;

  localparam logic [TIME_W-1:0] ON_MAX   = TIME_W'(3000);
  localparam logic [TIME_W-1:0] ON_CLAMP = TIME_W'(100);

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLED = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_QUIET   = CFG_IDX_W'(1);

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_PUSH = 1'b1;

  // pin_level in bit 0
  typedef struct packed {
    logic busy_res;
    logic on_clamped;
    logic push_accepted;
    logic pin_level;
  } res_t;

endpackage

>>> sv/buzzer_pattern_sequencer.sv
// ----------------------------------------------------------------------------
// buzzer_pattern_sequencer
// Beep FIFO in RAM with a phase timer driving an active-low buzzer pin.
// ----------------------------------------------------------------------------
// Results are registered; a tick that pops a beep reads the head entry from the
//   RAM first and produces its result from state S_POP.
// Throughput: 1 item per cycle while the output is not stalled and no tick pops.
// Output register plus skid stage; input stalls while both are full and while
//   the block is in S_POP for a popping tick.
// Reset: synchronous, active high; clears counters, pointers and timer, sets
//   the pin silent and restores enabled and quiet. The beep RAM is not cleared.
module buzzer_pattern_sequencer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [31:0]                   s_tdata,   // on_ms[15:0], off_ms[31:16]
  input  logic [0:0]                    s_tuser,   // kind[0]
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // pin_level, push_accepted,
                                                   // on_clamped, busy_res, 0[7:4]
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [0:0]                    cfg_data
);
  import bps_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_POP  = 1'b1;

  logic              state, state_next;
  logic [CNT_W-1:0]  fifo_count, fifo_count_next;
  logic [PTR_W-1:0]  read_pointer, read_pointer_next;
  logic [PTR_W-1:0]  write_pointer, write_pointer_next;
  logic [TIME_W-1:0] countdown, countdown_next;
  logic [TIME_W-1:0] pending_off, pending_off_next;
  logic              running, running_next;
  logic              pin_register, pin_register_next;
  logic              enabled, quiet;

  logic               ram_we, ram_re;
  logic [ENTRY_W-1:0] ram_rdata;
  logic [TIME_W-1:0]  delay;
  logic               accept, push_ok;

  logic prod_valid;
  res_t prod_res;
  logic out_valid, skid_valid;
  res_t out_res, skid_res;

  bps_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (ENTRY_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_pointer),
    .wdata (s_tdata),
    .re    (ram_re),
    .raddr (read_pointer),
    .rdata (ram_rdata)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE) && !skid_valid;
  assign accept    = s_tvalid && s_tready;
  assign push_ok   = enabled && (32'(fifo_count) <= 32'(QUEUE_LIMIT)) &&
                     (32'(fifo_count) < 32'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= 1'b1;
      quiet   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_ENABLED) begin
        enabled <= cfg_data[0];
      end else if (cfg_index == REG_QUIET) begin
        quiet <= cfg_data[0];
      end
    end
  end

  always_comb begin
    state_next         = state;
    fifo_count_next    = fifo_count;
    read_pointer_next  = read_pointer;
    write_pointer_next = write_pointer;
    countdown_next     = countdown;
    pending_off_next   = pending_off;
    running_next       = running;
    pin_register_next  = pin_register;
    ram_we             = 1'b0;
    ram_re             = 1'b0;
    prod_valid         = 1'b0;
    prod_res.on_clamped    = 1'b0;
    prod_res.push_accepted = 1'b0;
    delay = ram_rdata[TIME_W-1:0];
    if (state == S_POP) begin
      // finish the pop with the entry read last cycle
      if (delay > ON_MAX) begin
        delay = ON_CLAMP;
        prod_res.on_clamped = 1'b1;
      end
      if (delay == '0) begin
        delay = TIME_W'(1);
      end
      pending_off_next = ram_rdata[ENTRY_W-1:TIME_W];
      countdown_next   = delay;
      if (enabled && !quiet) begin
        pin_register_next = 1'b0;
      end
      state_next = S_IDLE;
      prod_valid = 1'b1;
    end else if (accept) begin
      if (s_tuser[0] == KIND_PUSH) begin
        prod_valid = 1'b1;
        if (push_ok) begin
          ram_we = 1'b1;
          write_pointer_next = (32'(write_pointer) == QUEUE_DEPTH - 1) ?
                               '0 : write_pointer + PTR_W'(1);
          fifo_count_next = fifo_count + CNT_W'(1);
          prod_res.push_accepted = 1'b1;
          if (!running) begin
            running_next   = 1'b1;
            countdown_next = TIME_W'(1);
          end
        end
      end else if (!running) begin
        prod_valid = 1'b1;
      end else if (countdown > TIME_W'(1)) begin
        countdown_next = countdown - TIME_W'(1);
        prod_valid = 1'b1;
      end else if (pending_off != '0) begin
        pin_register_next = 1'b1;
        countdown_next    = pending_off;
        pending_off_next  = '0;
        prod_valid = 1'b1;
      end else if (fifo_count == '0) begin
        pin_register_next = 1'b1;
        running_next      = 1'b0;
        countdown_next    = '0;
        prod_valid = 1'b1;
      end else begin
        // read the head entry, result follows next cycle
        ram_re = 1'b1;
        read_pointer_next = (32'(read_pointer) == QUEUE_DEPTH - 1) ?
                            '0 : read_pointer + PTR_W'(1);
        fifo_count_next = fifo_count - CNT_W'(1);
        state_next = S_POP;
      end
    end
    prod_res.pin_level = pin_register_next;
    prod_res.busy_res  = running_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fifo_count    <= '0;
      read_pointer  <= '0;
      write_pointer <= '0;
      countdown     <= '0;
      pending_off   <= '0;
      running       <= 1'b0;
      pin_register  <= 1'b1;
    end else begin
      state         <= state_next;
      fifo_count    <= fifo_count_next;
      read_pointer  <= read_pointer_next;
      write_pointer <= write_pointer_next;
      countdown     <= countdown_next;
      pending_off   <= pending_off_next;
      running       <= running_next;
      pin_register  <= pin_register_next;
    end
  end

  // output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid  <= skid_valid || prod_valid;
      skid_valid <= skid_valid && prod_valid;
    end else if (prod_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_res  <= skid_valid ? skid_res : prod_res;
      skid_res <= prod_res;
    end else if (prod_valid) begin
      skid_res <= prod_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_res};

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fifo_count) <= QUEUE_DEPTH)
    else $error("fifo count above depth");

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds data while output register is empty");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && state_next == S_POP) |-> fifo_count != '0)
    else $error("pop started on an empty queue");

  a_pop_single: assert property (@(posedge clk) disable iff (rst)
    state == S_POP |=> state == S_IDLE)
    else $error("pop state held more than one cycle");

  a_clamp_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_res.on_clamped) |-> out_res.busy_res)
    else $error("clamped result while not running");
`endif

endmodule

>>> sv/bps_ram.sv
// ----------------------------------------------------------------------------
// bps_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bps_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the buzzer pattern sequencer. A local model of the
// beep FIFO, phase timer and pin tracks every accepted tick and push. Each
// status word from the block is checked field by field, in order, against
// that model. Traffic is a short directed run followed by random tick/push
// streams under several enable and quiet settings, with random gaps and
// stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
  import bps_pkg::*;

  typedef struct {
    logic        kind;
    logic [15:0] on_ms;
    logic [15:0] off_ms;
  } beep_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [31:0]          s_tdata = '0;   // on_ms[15:0], off_ms[31:16]
  logic [0:0]           s_tuser = '0;   // kind[0]
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [7:0]           m_tdata;        // pin_level, push_accepted, on_clamped,
                                        // busy_res, 0[7:4]
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [0:0]           cfg_data = '0;

  buzzer_pattern_sequencer u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // model state
  logic [TIME_W-1:0] on_store  [QUEUE_DEPTH];
  logic [TIME_W-1:0] off_store [QUEUE_DEPTH];
  logic [CNT_W-1:0]  bz_count     = '0;
  logic [PTR_W-1:0]  bz_rd        = '0;
  logic [PTR_W-1:0]  bz_wr        = '0;
  logic [TIME_W-1:0] bz_countdown = '0;
  logic [TIME_W-1:0] bz_pend_off  = '0;
  logic              bz_running   = 1'b0;
  logic              bz_pin       = 1'b1;
  logic              bz_enabled   = 1'b1;
  logic              bz_quiet     = 1'b0;

  beep_t beep_items[$];
  res_t  status_q[$];

  int    n_queued    = 0;
  int    n_items     = 0;
  int    n_results   = 0;
  int    n_accepted  = 0;
  int    n_clamped   = 0;
  int    mismatches  = 0;
  int    gap_left    = 0;
  int    stall_left  = 0;
  int    hold_left   = 0;
  int    hold_seq    = 0;
  int    hold_seen   = 0;
  logic  calm        = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("buzzer_pattern_sequencer: mismatch");
    $finish;
  end

  function automatic res_t next_buzzer_status(input logic kind, input logic [15:0] on_t,
                                              input logic [15:0] off_t);
    res_t             r;
    logic [TIME_W-1:0] dly;
    r = '0;
    if (kind == KIND_PUSH) begin
      if (bz_enabled && bz_count <= QUEUE_LIMIT && bz_count < QUEUE_DEPTH) begin
        on_store[bz_wr]  = on_t;
        off_store[bz_wr] = off_t;
        bz_wr            = bz_wr + 1'b1;
        bz_count         = bz_count + 1'b1;
        r.push_accepted  = 1'b1;
        if (!bz_running) begin
          bz_running   = 1'b1;
          bz_countdown = 16'd1;
        end
      end
    end else if (bz_running) begin
      if (bz_countdown > 16'd1) begin
        bz_countdown = bz_countdown - 1'b1;
      end else if (bz_pend_off != '0) begin
        bz_pin       = 1'b1;
        bz_countdown = bz_pend_off;
        bz_pend_off  = '0;
      end else if (bz_count == '0) begin
        bz_pin       = 1'b1;
        bz_running   = 1'b0;
        bz_countdown = '0;
      end else begin
        dly         = on_store[bz_rd];
        bz_pend_off = off_store[bz_rd];
        bz_rd       = bz_rd + 1'b1;
        bz_count    = bz_count - 1'b1;
        if (dly > ON_MAX) begin
          dly          = ON_CLAMP;
          r.on_clamped = 1'b1;
        end
        if (dly == '0) dly = 16'd1;
        if (bz_enabled && !bz_quiet) bz_pin = 1'b0;
        bz_countdown = dly;
      end
    end
    r.pin_level = bz_pin;
    r.busy_res  = bz_running;
    return r;
  endfunction

  // sender
  always @(posedge clk) begin
    beep_t it;
    res_t  st;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= '0;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        st = next_buzzer_status(s_tuser[0], s_tdata[15:0], s_tdata[31:16]);
        status_q = {status_q, st};
        n_items++;
        n_accepted += st.push_accepted;
        n_clamped  += st.on_clamped;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (beep_items.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
          gap_left <= $urandom_range(0, 11);
          s_tvalid <= 1'b0;
        end else begin
          it = beep_items.pop_front();
          s_tvalid <= 1'b1;
          s_tuser  <= it.kind;
          s_tdata  <= {it.off_ms, it.on_ms};
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      m_tready   <= 1'b0;
      stall_left <= 0;
      hold_left  <= 0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= 99;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(0, 11);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // checker
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      got = res_t'(m_tdata[3:0]);
      if (status_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: status 0x%02h with nothing expected", $realtime, m_tdata);
      end else begin
        want = status_q.pop_front();
        if (got !== want || m_tdata[7:4] !== 4'h0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: status #%0d pin %b/%b accepted %b/%b clamped %b/%b busy %b/%b pad %h",
                     $realtime, n_results, want.pin_level, got.pin_level,
                     want.push_accepted, got.push_accepted, want.on_clamped,
                     got.on_clamped, want.busy_res, got.busy_res, m_tdata[7:4]);
        end
      end
    end
  end

  task automatic add_item(input logic kind, input logic [15:0] on_t, input logic [15:0] off_t);
    beep_t it;
    it.kind   = kind;
    it.on_ms  = on_t;
    it.off_ms = off_t;
    beep_items = {beep_items, it};
    n_queued++;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (n_results != n_queued);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ENABLED) bz_enabled = val;
    else if (idx == REG_QUIET) bz_quiet = val;
  endtask

  // mostly ticks with pushes of short beeps; rare long on-times and
  // bursts that overrun the queue limit
  task automatic gen_traffic(input int n, input logic wide);
    int pick;
    int k;
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        if (wide)
          add_item(KIND_PUSH, 16'($urandom), 16'($urandom));
        else if ($urandom_range(0, 49) == 0)
          add_item(KIND_PUSH, 16'($urandom_range(3001, 65535)), 16'($urandom_range(0, 4)));
        else
          add_item(KIND_PUSH, 16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)));
      end else if (pick == 15) begin
        repeat (12) add_item(KIND_PUSH, 16'($urandom_range(1, 3)), 16'd0);
      end else begin
        add_item(KIND_TICK, 16'($urandom), 16'($urandom));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // idle ticks, zero times, push while running, release phase, overrun
    add_item(KIND_TICK, 16'd0, 16'd0);
    add_item(KIND_TICK, 16'hFFFF, 16'hFFFF);
    add_item(KIND_PUSH, 16'd0, 16'd0);
    add_item(KIND_TICK, 16'd0, 16'd0);
    add_item(KIND_PUSH, 16'd2, 16'd3);
    repeat (6) add_item(KIND_TICK, 16'h5A5A, 16'hA5A5);
    add_item(KIND_PUSH, 16'd3001, 16'd0);
    repeat (9) add_item(KIND_PUSH, 16'd1, 16'd1);
    add_item(KIND_PUSH, 16'hFFFF, 16'd0);
    add_item(KIND_PUSH, 16'hFFFF, 16'hFFFF);
    gen_traffic(170, 1'b0);
    wait_drained();

    write_reg(REG_QUIET, 1'b1);
    gen_traffic(120, 1'b0);
    wait_drained();

    write_reg(REG_QUIET, 1'b0);
    write_reg(REG_ENABLED, 1'b1);
    @(posedge clk);
    hold_seq <= hold_seq + 1;
    gen_traffic(120, 1'b0);
    repeat (4) add_item(KIND_PUSH, 16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)));
    wait_drained();

    write_reg(REG_ENABLED, 1'b0);
    gen_traffic(120, 1'b1);
    wait_drained();

    write_reg(REG_ENABLED, 1'b1);
    @(posedge clk);
    calm <= 1'b1;
    gen_traffic(130, 1'b0);
    wait_drained();
    while (bz_running) begin
      repeat (16) add_item(KIND_TICK, 16'd0, 16'd0);
      wait_drained();
    end

    // boundary on-time, then full-range beeps
    add_item(KIND_PUSH, 16'd3000, 16'd0);
    add_item(KIND_TICK, 16'($urandom), 16'($urandom));
    repeat (6) begin
      add_item(KIND_PUSH, 16'($urandom), 16'($urandom));
      add_item(KIND_TICK, 16'($urandom), 16'($urandom));
    end
    wait_drained();
    repeat (10) @(posedge clk);

    if (status_q.size() != 0) mismatches++;
    $display("Ran %0d ticks and pushes through five enable/quiet settings, %0d statuses seen.",
             n_items, n_results);
    $display("Beeps queued: %0d, long on-times clamped: %0d, mismatches: %0d.",
             n_accepted, n_clamped, mismatches);
    if (mismatches == 0) begin
      $display("buzzer_pattern_sequencer: match");
    end else begin
      $display("buzzer_pattern_sequencer: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
sv/bps_pkg.sv
sv/bps_ram.sv
sv/buzzer_pattern_sequencer.sv
tb/tb.sv
